// ===== sv/vng_pkg.sv =====
package vng_pkg;

    localparam int PIXEL_BITS_DEF = 12;
    localparam int FIELD_BITS = 12;
    localparam int GRAD_BITS = 16;
    localparam int GAIN_BITS = 8;
    localparam int DIRS = 8;

    localparam logic [0:0] REG_K1_GAIN = 1'b0;
    localparam logic [0:0] REG_K2_GAIN = 1'b1;
    localparam logic [GAIN_BITS-1:0] K1_RESET = 8'd24;
    localparam logic [GAIN_BITS-1:0] K2_RESET = 8'd8;
    localparam logic [15:0] THR_SAT = 16'hffff;

    typedef struct packed {
        logic [FIELD_BITS-1:0] pixel_row0;
        logic [FIELD_BITS-1:0] pixel_row1;
        logic [FIELD_BITS-1:0] pixel_row2;
        logic [FIELD_BITS-1:0] pixel_row3;
        logic [FIELD_BITS-1:0] pixel_row4;
        logic                  line_start;
        logic                  green_centre;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  direction_mask;
        logic [3:0]  direction_count;
        logic [15:0] gradient_threshold;
    } out_item_t;

    // Gradient set handed from the window front to the threshold back end.
    typedef struct packed {
        logic [DIRS-1:0][GRAD_BITS-1:0] grad;
    } grad_set_t;

    // Absolute difference of two pixels.
    function automatic logic [GRAD_BITS-1:0] adiff(input logic [FIELD_BITS-1:0] a,
                                                   input logic [FIELD_BITS-1:0] b);
        logic [GRAD_BITS-1:0] ea;
        logic [GRAD_BITS-1:0] eb;
        ea = {{(GRAD_BITS-FIELD_BITS){1'b0}}, a};
        eb = {{(GRAD_BITS-FIELD_BITS){1'b0}}, b};
        return (ea > eb) ? ea - eb : eb - ea;
    endfunction

    // Halved absolute difference.
    function automatic logic [GRAD_BITS-1:0] hdiff(input logic [FIELD_BITS-1:0] a,
                                                   input logic [FIELD_BITS-1:0] b);
        return adiff(a, b) >> 1;
    endfunction

endpackage

// ===== sv/vng_front.sv =====
module vng_front
    import vng_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      q_valid,
    input  logic      q_ready,
    output grad_set_t q_data
);

    localparam logic [FIELD_BITS-1:0] PMASK = FIELD_BITS'((1 << PIXEL_BITS) - 1);

    // Four previous columns, column 0 oldest.
    logic [FIELD_BITS-1:0] win_reg [4][5];
    logic [2:0]            held_reg;
    logic                  v_reg;
    grad_set_t             g_reg;
    grad_set_t             g_next;
    logic [FIELD_BITS-1:0] p [26];
    logic [FIELD_BITS-1:0] cur [5];
    logic [2:0]            held;
    logic                  accept;
    logic                  green;

    assign in_ready = !v_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign q_valid  = v_reg;
    assign q_data   = g_reg;

    always_comb
    begin
        cur[0] = in_data.pixel_row0 & PMASK;
        cur[1] = in_data.pixel_row1 & PMASK;
        cur[2] = in_data.pixel_row2 & PMASK;
        cur[3] = in_data.pixel_row3 & PMASK;
        cur[4] = in_data.pixel_row4 & PMASK;
        held   = in_data.line_start ? 3'd0 : held_reg;
        green  = in_data.green_centre;
        p[0] = '0;
        for (int r = 0; r < 5; r++)
        begin
            for (int c = 0; c < 4; c++)
                p[r*5+c+1] = win_reg[c][r];
            p[r*5+5] = cur[r];
        end
    end

    // Eight directional gradients.
    always_comb
    begin
        g_next.grad[0] = adiff(p[3],p[13]) + adiff(p[8],p[18]) + hdiff(p[7],p[17])
                       + hdiff(p[9],p[19]) + hdiff(p[2],p[12]) + hdiff(p[4],p[14]);
        g_next.grad[2] = adiff(p[14],p[12]) + adiff(p[15],p[13]) + hdiff(p[9],p[7])
                       + hdiff(p[19],p[17]) + hdiff(p[10],p[8]) + hdiff(p[20],p[18]);
        g_next.grad[4] = adiff(p[18],p[8]) + adiff(p[23],p[13]) + hdiff(p[19],p[9])
                       + hdiff(p[17],p[7]) + hdiff(p[24],p[14]) + hdiff(p[22],p[12]);
        g_next.grad[6] = adiff(p[12],p[14]) + adiff(p[11],p[13]) + hdiff(p[17],p[19])
                       + hdiff(p[7],p[9]) + hdiff(p[16],p[18]) + hdiff(p[6],p[8]);
        if (green)
        begin
            g_next.grad[1] = adiff(p[9],p[17]) + adiff(p[5],p[13])
                           + adiff(p[4],p[12]) + adiff(p[10],p[18]);
            g_next.grad[3] = adiff(p[19],p[7]) + adiff(p[25],p[13])
                           + adiff(p[20],p[8]) + adiff(p[24],p[12]);
            g_next.grad[5] = adiff(p[17],p[9]) + adiff(p[21],p[13])
                           + adiff(p[22],p[14]) + adiff(p[16],p[8]);
            g_next.grad[7] = adiff(p[7],p[19]) + adiff(p[1],p[13])
                           + adiff(p[6],p[18]) + adiff(p[2],p[14]);
        end
        else
        begin
            g_next.grad[1] = adiff(p[9],p[17]) + adiff(p[5],p[13]) + hdiff(p[8],p[12])
                           + hdiff(p[14],p[18]) + hdiff(p[4],p[8]) + hdiff(p[10],p[14]);
            g_next.grad[3] = adiff(p[19],p[7]) + adiff(p[25],p[13]) + hdiff(p[14],p[8])
                           + hdiff(p[18],p[12]) + hdiff(p[20],p[14]) + hdiff(p[24],p[18]);
            g_next.grad[5] = adiff(p[17],p[9]) + adiff(p[21],p[13]) + hdiff(p[18],p[14])
                           + hdiff(p[12],p[8]) + hdiff(p[22],p[18]) + hdiff(p[16],p[12]);
            g_next.grad[7] = adiff(p[7],p[19]) + adiff(p[1],p[13]) + hdiff(p[12],p[18])
                           + hdiff(p[8],p[14]) + hdiff(p[6],p[12]) + hdiff(p[2],p[8]);
        end
    end

    // Column shift line and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            v_reg    <= 1'b0;
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 5; r++)
                    win_reg[c][r] <= '0;
        end
        else
        begin
            if (q_ready)
                v_reg <= 1'b0;
            if (accept)
            begin
                for (int c = 0; c < 3; c++)
                    win_reg[c] <= win_reg[c+1];
                win_reg[3] <= cur;
                held_reg   <= (held >= 3'd4) ? 3'd4 : held + 3'd1;
                v_reg      <= (held >= 3'd4);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            g_reg <= g_next;
    end

endmodule

// ===== sv/vng_queue.sv =====
module vng_queue
    import vng_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  grad_set_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output grad_set_t out_data
);

    // Two-entry queue between front and back.
    grad_set_t  mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_data;
    end

endmodule

// ===== sv/vng_back.sv =====
module vng_back
    import vng_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [GAIN_BITS-1:0] k1_gain,
    input  logic [GAIN_BITS-1:0] k2_gain,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  grad_set_t            q_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data
);

    // Stage A: min and max; stage B: gains; stage C: threshold and mask.
    logic                 a_v_reg, b_v_reg, c_v_reg;
    grad_set_t            a_g_reg, b_g_reg;
    logic [GRAD_BITS-1:0] a_mn_reg, a_mx_reg;
    logic [GRAD_BITS+GAIN_BITS-1:0] b_p1_reg, b_p2_reg;
    out_item_t            c_reg;
    logic                 adv_c, adv_b, adv_a;
    logic [GRAD_BITS-1:0] mn, mx;
    logic [GRAD_BITS+GAIN_BITS:0] sum;
    logic [GRAD_BITS+GAIN_BITS-4:0] acc;
    logic [15:0]          thr;
    logic [7:0]           msk;
    logic [3:0]           cnt;

    assign adv_c   = !c_v_reg || out_ready;
    assign adv_b   = !b_v_reg || adv_c;
    assign adv_a   = !a_v_reg || adv_b;
    assign q_ready = adv_a;
    assign out_valid = c_v_reg;
    assign out_data  = c_reg;

    always_comb
    begin
        mn = q_data.grad[0];
        mx = q_data.grad[0];
        for (int i = 1; i < DIRS; i++)
        begin
            if (q_data.grad[i] < mn) mn = q_data.grad[i];
            if (q_data.grad[i] > mx) mx = q_data.grad[i];
        end
    end

    always_comb
    begin
        sum = {1'b0, b_p1_reg} + {1'b0, b_p2_reg};
        acc = sum[GRAD_BITS+GAIN_BITS:4];
        thr = (acc > {{(GRAD_BITS+GAIN_BITS-19){1'b0}}, THR_SAT}) ? THR_SAT : acc[15:0];
        cnt = '0;
        for (int i = 0; i < DIRS; i++)
        begin
            msk[i] = b_g_reg.grad[i] < thr;
            cnt    = cnt + {3'b0, msk[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_a) a_v_reg <= q_valid;
            if (adv_b) b_v_reg <= a_v_reg;
            if (adv_c) c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && q_valid)
        begin
            a_g_reg  <= q_data;
            a_mn_reg <= mn;
            a_mx_reg <= mx;
        end
        if (adv_b && a_v_reg)
        begin
            b_g_reg  <= a_g_reg;
            b_p1_reg <= a_mn_reg * k1_gain;
            b_p2_reg <= (a_mx_reg - a_mn_reg) * k2_gain;
        end
        if (adv_c && b_v_reg)
        begin
            c_reg.direction_mask     <= msk;
            c_reg.direction_count    <= cnt;
            c_reg.gradient_threshold <= thr;
        end
    end

endmodule

// ===== sv/vng_gradient_direction_select_core.sv =====
// Gradient direction select for variable-number-of-gradients demosaicing. One beat is
// one 5-pixel Bayer column; after a line start, the fifth and every later column
// yields a result beat with the mask of directions below threshold, their count
// and the threshold. One column is taken every cycle unless back-pressure holds the
// front; results pass the registered window and gradients, the two-entry queue and
// the min/max, gain multiply and threshold stages. The user must write gains at index
// 0 (k1) and 1 (k2) only while the block is idle; the block itself does not enforce it.
module vng_gradient_direction_select_core
    import vng_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [GAIN_BITS-1:0] cfg_data
);

    logic [GAIN_BITS-1:0] k1_reg, k2_reg;
    logic      f_valid, f_ready, b_valid, b_ready;
    grad_set_t f_data, b_data;

    // Gain registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= K1_RESET;
            k2_reg <= K2_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_K1_GAIN: k1_reg <= cfg_data;
                REG_K2_GAIN: k2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vng_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_data,
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    vng_queue u_queue (
        .clk, .rst_n, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
    );

    vng_back u_back (
        .clk, .rst_n, .k1_gain(k1_reg), .k2_gain(k2_reg),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .out_valid, .out_ready, .out_data
    );

endmodule

// ===== sv/vng_checker.sv =====
module vng_checker
    import vng_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // The count matches the mask.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.direction_count == 4'($countones(out_data.direction_mask)))
        else $error("direction count does not match mask");

    // The output register never blocks input while it is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && $past(!out_valid) && $past(!out_valid, 2) && $past(!out_valid, 3)
        && $past(!out_valid, 4) |-> in_ready)
        else $error("input stalled with empty pipeline");

    // No result is valid when reset is released.
    a_reset: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

endmodule

bind vng_gradient_direction_select_core vng_checker u_checker (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_data
);
